[hdl/wake_strength_interpolator_assert.svh]
// Assertion macros for the wake strength interpolator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef WAKE_STRENGTH_INTERPOLATOR_ASSERT_SVH
`define WAKE_STRENGTH_INTERPOLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define WSI_ASSERT_IMP(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("wake strength interpolator: assertion failed");

// Next-cycle implication, disabled during reset
`define WSI_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("wake strength interpolator: assertion failed");

`endif

[hdl/wsi_pkg.sv]
// Shared types and constants for the wake strength interpolator.
// Used by the controller, datapath and top level; no dependencies.
package wsi_pkg;

    localparam int Y_W     = 32;            // Q16.16 positions and strengths
    localparam int D_W     = Y_W + 1;       // upper minus lower, exact
    localparam int E_W     = D_W + 1;       // difference of two jumps, exact
    localparam int LC_W    = 7;             // line_count register
    localparam int IDX_W   = 6;             // line_index field
    localparam int SPLIT_W = 17;            // low part of the jump difference
    localparam int MOP_W   = SPLIT_W + 1;   // signed multiplier operand
    localparam int PROD_W  = Y_W + MOP_W;
    localparam int ACC_W   = Y_W + E_W;

    localparam logic [LC_W-1:0] LC_RESET = 7'd2;

    localparam logic [Y_W-1:0] Y_MAX = {1'b0, {(Y_W-1){1'b1}}};
    localparam logic [Y_W-1:0] Y_MIN = {1'b1, {(Y_W-1){1'b0}}};

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        RES_WRITE_DONE = 2'd0,
        RES_OK         = 2'd1,
        RES_NO_PAIR    = 2'd2,
        RES_ZERO_SPAN  = 2'd3
    } result_code_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_FIRST,
        S_CHK_FIRST,
        S_CHK_LAST,
        S_SCAN,
        S_RD_A,
        S_RD_B,
        S_SPAN,
        S_ZCHK,
        S_DIV,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC,
        S_SUM,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic         write_line;
        logic         capture_y;
        logic         load_prev;
        logic         load_line_a;
        logic         load_line_b;
        logic         start_div;
        logic         load_coef;
        logic         mul_lo;
        logic         mul_hi;
        logic         acc_hi;
        logic         load_result;
        logic         set_code;
        result_code_t code;
        logic         load_out;
    } wsi_cmd_t;

    typedef struct packed {
        logic y_below;
        logic pair_hit;
        logic span_zero;
        logic div_done;
    } wsi_sts_t;

endpackage

[hdl/wsi_div.sv]
// Sequential signed divider, one quotient bit per cycle, truncating toward zero.
// Standalone unit used by the datapath; no package dependencies.
module wsi_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [NUM_W-1:0] num,
    input  logic signed [DEN_W-1:0] den,
    output logic                    done,
    output logic signed [NUM_W:0]   quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             fix_reg, fix_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [NUM_W-1:0]        sh_reg;
    logic [DEN_W-1:0]        rem_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    neg_reg;
    logic signed [NUM_W:0]   quo_reg;

    logic [NUM_W-1:0] num_mag;
    logic [DEN_W-1:0] den_mag;
    logic [DEN_W+1:0] trial;
    logic             take;
    logic [DEN_W-1:0] rem_step;

    assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    assign den_mag = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);

    // restoring step: bring down the next dividend bit and try the subtract
    assign trial    = {1'b0, rem_reg, sh_reg[NUM_W-1]} - {2'b00, den_reg};
    assign take     = !trial[DEN_W+1];
    assign rem_step = take ? trial[DEN_W-1:0] : {rem_reg[DEN_W-2:0], sh_reg[NUM_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                fix_next  = 1'b1;
            end
        end
        else if (fix_reg)
        begin
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= num_mag;
            rem_reg <= '0;
            den_reg <= den_mag;
            neg_reg <= num[NUM_W-1] ^ den[DEN_W-1];
        end
        else if (busy_reg)
        begin
            sh_reg  <= {sh_reg[NUM_W-2:0], take};
            rem_reg <= rem_step;
        end
        // apply the sign once the magnitude is complete
        if (fix_reg)
        begin
            quo_reg <= neg_reg ? -signed'({1'b0, sh_reg}) : signed'({1'b0, sh_reg});
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

[hdl/wsi_dpath.sv]
// Datapath: breakpoint table memory, bracket compares, coefficient and strength arithmetic.
// Depends on wsi_pkg and wsi_div; driven by wsi_ctrl through wsi_cmd_t.
module wsi_dpath
    import wsi_pkg::*;
#(
    parameter  int MAX_LINES = 64,
    parameter  int FRAC_BITS = 16,
    localparam int AW        = $clog2(MAX_LINES)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  wsi_cmd_t                cmd,
    output wsi_sts_t                sts,
    input  logic [AW-1:0]           rd_addr,
    input  logic [IDX_W-1:0]        line_index,
    input  logic signed [Y_W-1:0]   line_y,
    input  logic signed [Y_W-1:0]   upper_mu,
    input  logic signed [Y_W-1:0]   lower_mu,
    input  logic signed [Y_W-1:0]   query_y,
    output logic signed [Y_W-1:0]   strength,
    output logic signed [Y_W-1:0]   coefficient,
    output logic [1:0]              status,
    output logic                    saturated
);

    localparam int W_W   = Y_W + D_W;
    localparam int NUM_W = D_W + FRAC_BITS;

    // table memory: each row holds the position and the upper-lower jump
    logic [W_W-1:0] mem [MAX_LINES];
    logic [W_W-1:0] rdata_reg;

    logic [31:0]             widx;
    logic                    wr_ok;
    logic [AW-1:0]           waddr;
    logic signed [D_W-1:0]   d_new;

    logic signed [Y_W-1:0]   rd_pos;
    logic signed [D_W-1:0]   rd_d;

    logic signed [Y_W-1:0]   y_reg;
    logic signed [Y_W-1:0]   prev_reg;
    logic signed [Y_W-1:0]   y1_reg;
    logic signed [D_W-1:0]   d1_reg;
    logic signed [D_W-1:0]   span_reg;
    logic signed [D_W-1:0]   ny_reg;
    logic signed [E_W-1:0]   e_reg;
    logic signed [Y_W-1:0]   c_reg;
    logic                    csat_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0] acc_reg;

    result_code_t            pend_code_reg;
    logic [Y_W-1:0]          pend_strength_reg;
    logic [Y_W-1:0]          pend_coef_reg;
    logic                    pend_sat_reg;

    result_code_t            out_code_reg;
    logic [Y_W-1:0]          out_strength_reg;
    logic [Y_W-1:0]          out_coef_reg;
    logic                    out_sat_reg;

    logic signed [NUM_W-1:0] div_num;
    logic                    div_done;
    logic signed [NUM_W:0]   div_q;
    logic [NUM_W-Y_W+1:0]    q_top;
    logic                    q_fits;
    logic [Y_W-1:0]          c_clip;

    logic signed [MOP_W-1:0]  m_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  acc_shift;
    logic signed [ACC_W-1:0]  sum;
    logic [ACC_W-Y_W:0]       s_top;
    logic                     s_fits;
    logic [Y_W-1:0]           s_clip;

    assign widx  = 32'(line_index);
    assign wr_ok = widx < 32'(MAX_LINES);
    assign waddr = widx[AW-1:0];
    assign d_new = D_W'(upper_mu) - D_W'(lower_mu);

    always_ff @(posedge clk)
    begin
        if (cmd.write_line && wr_ok)
        begin
            mem[waddr] <= {line_y, d_new};
        end
        rdata_reg <= mem[rd_addr];
    end

    assign rd_pos = rdata_reg[W_W-1:D_W];
    assign rd_d   = rdata_reg[D_W-1:0];

    assign sts.y_below   = y_reg < rd_pos;
    assign sts.pair_hit  = (prev_reg <= y_reg) && (y_reg < rd_pos);
    assign sts.span_zero = (span_reg == '0);
    assign sts.div_done  = div_done;

    assign div_num = {ny_reg, {FRAC_BITS{1'b0}}};

    wsi_div #(
        .NUM_W (NUM_W),
        .DEN_W (D_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num   (div_num),
        .den   (span_reg),
        .done  (div_done),
        .quo   (div_q)
    );

    // clip the quotient: it fits when the bits above bit 30 all agree
    assign q_top  = div_q[NUM_W:Y_W-1];
    assign q_fits = (&q_top) || !(|q_top);
    assign c_clip = q_fits ? div_q[Y_W-1:0] : (div_q[NUM_W] ? Y_MIN : Y_MAX);

    // 32 x 34 product taken as two partial products through one multiplier
    assign m_b  = cmd.mul_hi ? MOP_W'(signed'(e_reg[E_W-1:SPLIT_W]))
                             : signed'({1'b0, e_reg[SPLIT_W-1:0]});
    assign prod = c_reg * m_b;

    assign acc_shift = acc_reg >>> FRAC_BITS;
    assign sum       = ACC_W'(d1_reg) + acc_shift;
    assign s_top     = sum[ACC_W-1:Y_W-1];
    assign s_fits    = (&s_top) || !(|s_top);
    assign s_clip    = s_fits ? sum[Y_W-1:0] : (sum[ACC_W-1] ? Y_MIN : Y_MAX);

    always_ff @(posedge clk)
    begin
        if (cmd.capture_y)
        begin
            y_reg <= query_y;
        end
        if (cmd.load_prev)
        begin
            prev_reg <= rd_pos;
        end
        if (cmd.load_line_a)
        begin
            y1_reg <= rd_pos;
            d1_reg <= rd_d;
        end
        if (cmd.load_line_b)
        begin
            span_reg <= D_W'(rd_pos) - D_W'(y1_reg);
            ny_reg   <= D_W'(y_reg) - D_W'(y1_reg);
            e_reg    <= E_W'(rd_d) - E_W'(d1_reg);
        end
        if (cmd.load_coef)
        begin
            c_reg    <= c_clip;
            csat_reg <= !q_fits;
        end
        if (cmd.mul_lo || cmd.mul_hi)
        begin
            prod_reg <= prod;
        end
        if (cmd.mul_hi)
        begin
            acc_reg <= ACC_W'(prod_reg);
        end
        else if (cmd.acc_hi)
        begin
            acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< SPLIT_W);
        end

        if (cmd.set_code)
        begin
            pend_code_reg     <= cmd.code;
            pend_strength_reg <= '0;
            pend_coef_reg     <= '0;
            pend_sat_reg      <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            pend_code_reg     <= RES_OK;
            pend_strength_reg <= s_clip;
            pend_coef_reg     <= c_reg;
            pend_sat_reg      <= csat_reg || !s_fits;
        end

        if (cmd.load_out)
        begin
            out_code_reg     <= pend_code_reg;
            out_strength_reg <= pend_strength_reg;
            out_coef_reg     <= pend_coef_reg;
            out_sat_reg      <= pend_sat_reg;
        end
    end

    assign strength    = out_strength_reg;
    assign coefficient = out_coef_reg;
    assign status      = out_code_reg;
    assign saturated   = out_sat_reg;

endmodule

[hdl/wsi_ctrl.sv]
// Controller: handshakes, line_count register and the query sequencer.
// Depends on wsi_pkg and the assertion macro header; drives wsi_dpath.
`include "wake_strength_interpolator_assert.svh"

module wsi_ctrl
    import wsi_pkg::*;
#(
    parameter  int MAX_LINES = 64,
    localparam int AW        = $clog2(MAX_LINES)
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            op,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [LC_W-1:0] cfg_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [AW-1:0]   rd_addr,
    output wsi_cmd_t        cmd,
    input  wsi_sts_t        sts
);

    localparam int CW = (AW + 1 > LC_W) ? AW + 1 : LC_W;

    state_t          state_reg, state_next;
    logic [LC_W-1:0] line_count_reg;
    logic            out_valid_reg, out_valid_next;
    logic [AW-1:0]   nm1_reg, nm1_next;
    logic [AW-1:0]   k_reg, k_next;
    logic [AW-1:0]   a_reg, a_next;
    logic            found_reg, found_next;

    logic [CW-1:0]   lc_ext;
    logic [CW-1:0]   n_val;
    logic [AW-1:0]   n_last;
    logic            scan_hit;

    // clamp the line count into the table
    always_comb
    begin
        lc_ext = CW'(line_count_reg);
        if (lc_ext < CW'(2))
        begin
            n_val = CW'(2);
        end
        else if (lc_ext > CW'(MAX_LINES))
        begin
            n_val = CW'(MAX_LINES);
        end
        else
        begin
            n_val = lc_ext;
        end
        n_last = AW'(n_val - CW'(1));
    end

    // the first scan cycle only primes the previous position
    assign scan_hit = (k_reg != AW'(1)) && sts.pair_hit;

    always_comb
    begin
        state_next     = state_reg;
        nm1_next       = nm1_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        rd_addr        = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture_y = 1'b1;
                    nm1_next      = n_last;
                    if (op == OP_QUERY)
                    begin
                        state_next = S_RD_FIRST;
                    end
                    else
                    begin
                        cmd.write_line = 1'b1;
                        cmd.set_code   = 1'b1;
                        cmd.code       = RES_WRITE_DONE;
                        state_next     = S_FINISH;
                    end
                end
            end
            S_RD_FIRST:
            begin
                rd_addr    = AW'(1);
                state_next = S_CHK_FIRST;
            end
            S_CHK_FIRST:
            begin
                rd_addr = nm1_reg;
                if (sts.y_below)
                begin
                    a_next     = '0;
                    state_next = S_RD_A;
                end
                else
                begin
                    state_next = S_CHK_LAST;
                end
            end
            S_CHK_LAST:
            begin
                rd_addr = AW'(1);
                if (!sts.y_below)
                begin
                    a_next     = nm1_reg - AW'(1);
                    state_next = S_RD_A;
                end
                else
                begin
                    k_next     = AW'(1);
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                rd_addr       = k_reg + AW'(1);
                cmd.load_prev = 1'b1;
                // later matches overwrite earlier ones
                if (scan_hit)
                begin
                    a_next     = k_reg - AW'(1);
                    found_next = 1'b1;
                end
                if (k_reg == nm1_reg)
                begin
                    if (scan_hit || found_reg)
                    begin
                        state_next = S_RD_A;
                    end
                    else
                    begin
                        cmd.set_code = 1'b1;
                        cmd.code     = RES_NO_PAIR;
                        state_next   = S_FINISH;
                    end
                end
                else
                begin
                    k_next = k_reg + AW'(1);
                end
            end
            S_RD_A:
            begin
                rd_addr    = a_reg;
                state_next = S_RD_B;
            end
            S_RD_B:
            begin
                rd_addr         = a_reg + AW'(1);
                cmd.load_line_a = 1'b1;
                state_next      = S_SPAN;
            end
            S_SPAN:
            begin
                cmd.load_line_b = 1'b1;
                state_next      = S_ZCHK;
            end
            S_ZCHK:
            begin
                if (sts.span_zero)
                begin
                    cmd.set_code = 1'b1;
                    cmd.code     = RES_ZERO_SPAN;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.load_coef = 1'b1;
                    state_next    = S_MUL_LO;
                end
            end
            S_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_hi = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.load_result = 1'b1;
                state_next      = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            line_count_reg <= LC_RESET;
            out_valid_reg  <= 1'b0;
            nm1_reg        <= '0;
            k_reg          <= '0;
            a_reg          <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            nm1_reg       <= nm1_next;
            k_reg         <= k_next;
            a_reg         <= a_next;
            found_reg     <= found_next;
            if (cfg_valid)
            begin
                line_count_reg <= cfg_data;
            end
        end
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;

    `WSI_ASSERT_NEXT(a_finish_hold, clk, rst_n, (state_reg == S_FINISH) && out_valid_reg && !out_ready, state_reg == S_FINISH)
    `WSI_ASSERT_IMP(a_scan_range, clk, rst_n, state_reg == S_SCAN, (k_reg != '0) && (k_reg <= nm1_reg))
    `WSI_ASSERT_IMP(a_pair_in_table, clk, rst_n, state_reg == S_RD_A, a_reg < nm1_reg)
    `WSI_ASSERT_IMP(a_div_done_state, clk, rst_n, sts.div_done, state_reg == S_DIV)

endmodule

[hdl/wake_strength_interpolator.sv]
// Channel   Handshake               Payload
// in        in_valid / in_ready     op, line_index, line_y, upper_mu, lower_mu, query_y
// out       out_valid / out_ready   strength, coefficient, status, saturated
// cfg       cfg_valid / cfg_ready   cfg_data (line_count)
//
// A query's bracket scan reads one table line per cycle through the single memory read
// port, then the divider produces one quotient bit per cycle.
// One item is worked on at a time; a new item is taken while a finished result waits.
// Reset clears control state only; table lines read back undefined until written.
// A stalled output holds the finished item in the output register.
//
// Top level of the wake strength interpolator; depends on wsi_pkg, wsi_ctrl and wsi_dpath.
module wake_strength_interpolator
    import wsi_pkg::*;
#(
    parameter int MAX_LINES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  op,
    input  logic [IDX_W-1:0]      line_index,
    input  logic signed [Y_W-1:0] line_y,
    input  logic signed [Y_W-1:0] upper_mu,
    input  logic signed [Y_W-1:0] lower_mu,
    input  logic signed [Y_W-1:0] query_y,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic signed [Y_W-1:0] strength,
    output logic signed [Y_W-1:0] coefficient,
    output logic [1:0]            status,
    output logic                  saturated,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [LC_W-1:0]       cfg_data
);

    localparam int AW = $clog2(MAX_LINES);

    wsi_cmd_t      cmd;
    wsi_sts_t      sts;
    logic [AW-1:0] rd_addr;

    wsi_ctrl #(
        .MAX_LINES (MAX_LINES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rd_addr   (rd_addr),
        .cmd       (cmd),
        .sts       (sts)
    );

    wsi_dpath #(
        .MAX_LINES (MAX_LINES),
        .FRAC_BITS (FRAC_BITS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .rd_addr     (rd_addr),
        .line_index  (line_index),
        .line_y      (line_y),
        .upper_mu    (upper_mu),
        .lower_mu    (lower_mu),
        .query_y     (query_y),
        .strength    (strength),
        .coefficient (coefficient),
        .status      (status),
        .saturated   (saturated)
    );

endmodule

[verif/wsi_strength_checker.sv]
// Result checker for the wake strength interpolator testbench.
// Watches the item, result and line-count channels and predicts every result from its own
// copy of the breakpoint table; depends on wsi_pkg.
module wsi_strength_checker
    import wsi_pkg::*;
#(
    parameter int MAX_LINES = 64,
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic                  op,
    input  logic [IDX_W-1:0]      line_index,
    input  logic signed [Y_W-1:0] line_y,
    input  logic signed [Y_W-1:0] upper_mu,
    input  logic signed [Y_W-1:0] lower_mu,
    input  logic signed [Y_W-1:0] query_y,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic signed [Y_W-1:0] strength,
    input  logic signed [Y_W-1:0] coefficient,
    input  logic [1:0]            status,
    input  logic                  saturated,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [LC_W-1:0]       cfg_data,
    output int                    fails,
    output int                    pending
);

    localparam int     REPORT_LIMIT = 10;
    localparam longint S32_MAX      = 64'sh0000_0000_7FFF_FFFF;
    localparam longint S32_MIN      = -64'sh0000_0000_8000_0000;

    typedef struct {
        logic signed [Y_W-1:0] strength;
        logic signed [Y_W-1:0] coefficient;
        result_code_t          status;
        logic                  saturated;
    } strength_t;

    longint          line_pos   [MAX_LINES];
    longint          line_upper [MAX_LINES];
    longint          line_lower [MAX_LINES];
    logic [LC_W-1:0] lines_in_use;
    strength_t       awaited [$];

    function automatic longint clip32(input longint v, inout bit hit);
        if (v > S32_MAX)
        begin
            hit = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            hit = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    function automatic strength_t predict_query(input longint y);
        strength_t r;
        int        n;
        int        a;
        bit        found;
        bit        hit;
        longint    y1;
        longint    span;
        longint    c;
        longint    d1;
        longint    e;
        longint    eh;
        longint    el;
        longint    s;
        r.strength    = '0;
        r.coefficient = '0;
        r.status      = RES_NO_PAIR;
        r.saturated   = 1'b0;
        n = int'(lines_in_use);
        if (n < 2)
            n = 2;
        if (n > MAX_LINES)
            n = MAX_LINES;
        a     = 0;
        found = 1'b1;
        if (y < line_pos[1])
            a = 0;
        else if (y >= line_pos[n - 1])
            a = n - 2;
        else
        begin
            // last bracketing pair wins
            found = 1'b0;
            for (int i = 1; i + 1 < n; i++)
                if (line_pos[i] <= y && line_pos[i + 1] > y)
                begin
                    a     = i;
                    found = 1'b1;
                end
        end
        if (!found)
            return r;
        y1   = line_pos[a];
        span = line_pos[a + 1] - y1;
        if (span == 0)
        begin
            r.status = RES_ZERO_SPAN;
            return r;
        end
        hit = 1'b0;
        c   = clip32(((y - y1) <<< FRAC_BITS) / span, hit);
        d1  = line_upper[a] - line_lower[a];
        e   = (line_upper[a + 1] - line_lower[a + 1]) - d1;
        // split the jump difference so that c times it stays within 64 bits
        eh  = e >>> FRAC_BITS;
        el  = e - (eh <<< FRAC_BITS);
        s   = clip32(d1 + c * eh + ((c * el) >>> FRAC_BITS), hit);
        r.strength    = s[Y_W-1:0];
        r.coefficient = c[Y_W-1:0];
        r.status      = RES_OK;
        r.saturated   = hit;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        strength_t want;
        if (!rst_n)
        begin
            lines_in_use = LC_RESET;
            awaited.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (awaited.size() == 0)
                begin
                    fails++;
                    if (fails <= REPORT_LIMIT)
                        $display("result with nothing awaited: s=%h c=%h st=%0d sat=%b",
                                 strength, coefficient, status, saturated);
                end
                else
                begin
                    want = awaited.pop_front();
                    if (strength !== want.strength || coefficient !== want.coefficient ||
                        status !== want.status || saturated !== want.saturated)
                    begin
                        fails++;
                        if (fails <= REPORT_LIMIT)
                            $display("result differs: want s=%h c=%h st=%0d sat=%b, got s=%h c=%h st=%0d sat=%b",
                                     want.strength, want.coefficient, want.status,
                                     want.saturated, strength, coefficient, status, saturated);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                lines_in_use = cfg_data;
            if (in_valid && in_ready)
            begin
                if (op == OP_WRITE)
                begin
                    if (line_index < MAX_LINES)
                    begin
                        line_pos[line_index]   = line_y;
                        line_upper[line_index] = upper_mu;
                        line_lower[line_index] = lower_mu;
                    end
                    want.strength    = '0;
                    want.coefficient = '0;
                    want.status      = RES_WRITE_DONE;
                    want.saturated   = 1'b0;
                end
                else
                    want = predict_query(query_y);
                // append to the tail of the awaited results
                awaited = {awaited, want};
            end
        end
        pending <= awaited.size();
    end

endmodule

[verif/tb_wake_strength_interpolator.sv]
// Testbench top for the wake strength interpolator: clock, reset, item and line-count
// stimulus, random output stalls and the verdict. Depends on wsi_pkg, the block and
// wsi_strength_checker.
module tb_wake_strength_interpolator;
    import wsi_pkg::*;

    localparam int     LINES          = 64;
    localparam int     FRAC           = 16;
    localparam int     PERIOD         = 10;
    localparam int     ITEM_TARGET    = 1600;
    localparam int     CYCLE_LIMIT    = 2_000_000;
    localparam int     SQUEEZE_CYCLES = 600;
    localparam int     DRAIN_CYCLES   = 150;
    localparam longint Y_MAX_L        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint Y_MIN_L        = -64'sh0000_0000_8000_0000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  op          = OP_WRITE;
    logic [IDX_W-1:0]      line_index  = '0;
    logic signed [Y_W-1:0] line_y      = '0;
    logic signed [Y_W-1:0] upper_mu    = '0;
    logic signed [Y_W-1:0] lower_mu    = '0;
    logic signed [Y_W-1:0] query_y     = '0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic signed [Y_W-1:0] strength;
    logic signed [Y_W-1:0] coefficient;
    logic [1:0]            status;
    logic                  saturated;
    logic                  cfg_valid   = 1'b0;
    logic                  cfg_ready;
    logic [LC_W-1:0]       cfg_data    = LC_RESET;

    int                    fails;
    int                    pending;
    int                    sent        = 0;
    int                    cycles      = 0;
    bit                    burst       = 1'b0;
    int                    squeeze_req = 0;
    int                    squeeze_seen = 0;
    int                    sink_hold   = 0;
    int                    sink_mode_left = 0;
    bit                    sink_eager  = 1'b0;
    logic signed [Y_W-1:0] placed_y [LINES];

    wake_strength_interpolator #(
        .MAX_LINES (LINES),
        .FRAC_BITS (FRAC)
    ) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .line_index  (line_index),
        .line_y      (line_y),
        .upper_mu    (upper_mu),
        .lower_mu    (lower_mu),
        .query_y     (query_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .strength    (strength),
        .coefficient (coefficient),
        .status      (status),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    wsi_strength_checker #(
        .MAX_LINES (LINES),
        .FRAC_BITS (FRAC)
    ) strength_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .line_index  (line_index),
        .line_y      (line_y),
        .upper_mu    (upper_mu),
        .lower_mu    (lower_mu),
        .query_y     (query_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .strength    (strength),
        .coefficient (coefficient),
        .status      (status),
        .saturated   (saturated),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fails       (fails),
        .pending     (pending)
    );

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("wake_strength_interpolator: mismatch");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Result sink: spells of eager acceptance, random stalls, and one long hold on request
    always @(posedge clk)
    begin
        if (squeeze_req != squeeze_seen)
        begin
            squeeze_seen = squeeze_req;
            sink_hold    = SQUEEZE_CYCLES;
        end
        if (sink_mode_left == 0)
        begin
            sink_eager     = ($urandom_range(0, 3) == 0);
            sink_mode_left = $urandom_range(50, 400);
        end
        sink_mode_left--;
        if (sink_hold == 0 && !sink_eager && $urandom_range(0, 2) == 0)
            sink_hold = gap_len();
        out_ready <= (sink_hold == 0);
        if (sink_hold > 0)
            sink_hold--;
    end

    function automatic logic [Y_W-1:0] rand_mu();
        if ($urandom_range(0, 9) < 7)
            return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        return $urandom;
    endfunction

    function automatic logic [Y_W-1:0] pick_query(input int n);
        int     i;
        int     r;
        longint lo;
        longint hi;
        longint y;
        i  = $urandom_range(0, n - 2);
        lo = placed_y[i];
        hi = placed_y[i + 1];
        if (lo > hi)
        begin
            y  = lo;
            lo = hi;
            hi = y;
        end
        r = $urandom_range(0, 99);
        if (r < 40)
            y = lo + longint'($urandom_range(0, 32'(hi - lo)));
        else if (r < 55)
            y = placed_y[$urandom_range(0, n - 1)];
        else if (r < 65)
            y = longint'(placed_y[$urandom_range(0, n - 1)]) + ($urandom_range(0, 1) ? 1 : -1);
        else if (r < 68)
            y = Y_MIN_L;
        else if (r < 71)
            y = Y_MAX_L;
        else if (r < 78)
            y = longint'(placed_y[0]) - longint'($urandom_range(0, 32'h0008_0000));
        else if (r < 85)
            y = longint'(placed_y[n - 1]) + longint'($urandom_range(0, 32'h0008_0000));
        else
            y = longint'($signed($urandom));
        if (y > Y_MAX_L)
            y = Y_MAX_L;
        if (y < Y_MIN_L)
            y = Y_MIN_L;
        return y[Y_W-1:0];
    endfunction

    function automatic logic [LC_W-1:0] pick_line_count(input int phase);
        int r;
        case (phase)
            0: return 7'd64;
            1: return 7'd127;
            2: return 7'd65;
            3: return 7'd3;
            default: ;
        endcase
        r = $urandom_range(0, 99);
        if (r < 75)
            return LC_W'($urandom_range(2, 10));
        if (r < 93)
            return LC_W'($urandom_range(11, 63));
        return LC_W'($urandom_range(64, 127));
    endfunction

    // Hold valid and payload until the item is taken, then idle for a random gap
    task automatic offer();
        int gap;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        sent++;
        gap = burst ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_line(input logic [IDX_W-1:0] idx, input logic [Y_W-1:0] y,
                              input logic [Y_W-1:0] up_v, input logic [Y_W-1:0] low_v);
        op            <= OP_WRITE;
        line_index    <= idx;
        line_y        <= y;
        upper_mu      <= up_v;
        lower_mu      <= low_v;
        query_y       <= $urandom;
        placed_y[idx]  = y;
        offer();
    endtask

    task automatic ask_strength(input logic [Y_W-1:0] y);
        op         <= OP_QUERY;
        query_y    <= y;
        line_index <= IDX_W'($urandom);
        line_y     <= $urandom;
        upper_mu   <= $urandom;
        lower_mu   <= $urandom;
        offer();
    endtask

    task automatic wait_drain();
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic set_line_count(input logic [LC_W-1:0] value);
        in_valid <= 1'b0;
        wait_drain();
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Fill lines 0..n-1: sorted narrow or wide, sorted with repeats, or scattered
    task automatic load_table(input int n);
        int     shape;
        longint y;
        longint step_max;
        longint pos_v;
        longint step;
        shape = $urandom_range(0, 99);
        if (shape < 15)
        begin
            y        = Y_MIN_L + longint'($urandom_range(0, 1000));
            step_max = 64'd4294960000 / n;
        end
        else
        begin
            y        = longint'($signed($urandom)) >>> 1;
            step_max = 32'h0004_0000;
        end
        for (int i = 0; i < n; i++)
        begin
            if (shape >= 85)
                pos_v = y + longint'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
            else
            begin
                pos_v = y;
                if (shape >= 70 && $urandom_range(0, 2) == 0)
                    step = 0;
                else
                    step = $urandom_range(1, 32'(step_max));
                y = y + step;
            end
            write_line(IDX_W'(i), pos_v[Y_W-1:0], rand_mu(), rand_mu());
        end
    endtask

    initial
    begin
        int                    phase;
        int                    n;
        int                    k;
        logic [LC_W-1:0]       lc;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // two lines in use after reset
        write_line(IDX_W'(0), 32'h0000_0000, 32'h0003_0000, 32'h0001_0000);
        write_line(IDX_W'(1), 32'h0002_0000, 32'h0005_0000, 32'hFFFF_0000);
        ask_strength(32'h0001_0000);
        ask_strength(32'h0000_0000);
        ask_strength(32'h0002_0000);
        ask_strength(Y_MIN);
        ask_strength(Y_MAX);
        // one-lsb span drives the coefficient out of range
        write_line(IDX_W'(1), 32'h0000_0001, 32'h0005_0000, 32'hFFFF_0000);
        ask_strength(32'h0001_0000);
        // coincident lines, queried from both sides
        write_line(IDX_W'(1), 32'h0000_0000, 32'h0005_0000, 32'hFFFF_0000);
        ask_strength(32'h0000_0005);
        ask_strength(32'hFFFF_FFFB);
        // extreme positions and jumps, strength clips at the ends
        write_line(IDX_W'(0), Y_MIN, Y_MAX, Y_MIN);
        write_line(IDX_W'(1), Y_MAX, Y_MIN, Y_MAX);
        ask_strength(32'h0000_0000);
        ask_strength(Y_MIN);
        ask_strength(Y_MAX);
        write_line(IDX_W'(63), Y_MAX, Y_MIN, Y_MAX);
        // line counts below two act as two
        set_line_count(7'd0);
        ask_strength(32'h4000_0000);
        set_line_count(7'd1);
        ask_strength(32'hC000_0000);

        phase = 0;
        while (sent < ITEM_TARGET)
        begin
            lc = pick_line_count(phase);
            set_line_count(lc);
            n = (lc < 2) ? 2 : ((lc > LINES) ? LINES : int'(lc));
            burst = 1'b0;
            load_table(n);
            burst = ($urandom_range(0, 3) == 0);
            if (phase == 2)
                squeeze_req <= squeeze_req + 1;
            for (int j = 0; j < $urandom_range(40, 100); j++)
            begin
                if (phase == 3 && j == 20)
                begin
                    in_valid <= 1'b0;
                    wait_drain();
                end
                if ($urandom_range(0, 99) < 15)
                begin
                    k = $urandom_range(0, LINES - 1);
                    write_line(IDX_W'(k),
                               (k < n && $urandom_range(0, 1) == 1) ? placed_y[k] : $urandom,
                               rand_mu(), rand_mu());
                end
                else
                    ask_strength(pick_query(n));
            end
            phase++;
        end

        in_valid <= 1'b0;
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && pending == 0)
            $display("wake_strength_interpolator: match");
        else
            $display("wake_strength_interpolator: mismatch");
        $finish;
    end

endmodule
